>>> hdl/atkinson_mono_dither_assert.svh
// Assertion macros shared by the Atkinson mono dither modules.
`ifndef ATKINSON_MONO_DITHER_ASSERT_SVH
`define ATKINSON_MONO_DITHER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AMD_ASSERT_NOW(lbl, ante, cons, msg)
`define AMD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/amd_pkg.sv
// Package with the constants, types and saturation helpers of the Atkinson mono dither.
package amd_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);

    localparam int LINE_WIDTH_W = 11;
    localparam int LINE_WIDTH_RESET = 1024;
    localparam int WCMP_W = (CNT_W > LINE_WIDTH_W) ? CNT_W : LINE_WIDTH_W;

    localparam int PIXEL_W = 8;
    localparam int ERR_W = 10;
    localparam int SUM_W = ERR_W + 1;
    localparam int VAL_W = ERR_W + 2;
    localparam int ERR_MAX = 511;
    localparam int ERR_MIN = -512;

    localparam int QUANT_MID = 128;
    localparam int WHITE_LEVEL = 255;
    localparam int ERR_DIV = 8;
    localparam int ERR_SHIFT = $clog2(ERR_DIV);

    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam int REG_LINE_WIDTH = 0;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_start;
        logic [ADDR_W-1:0]  col;
    } amd_item_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [ERR_W-1:0]  data;
    } amd_wr_t;

    function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [SUM_W-1:0] s);
        logic signed [ERR_W-1:0] r;
        if (s > ERR_MAX)
        begin
            r = ERR_W'(ERR_MAX);
        end
        else if (s < ERR_MIN)
        begin
            r = ERR_W'(ERR_MIN);
        end
        else
        begin
            r = ERR_W'(s);
        end
        return r;
    endfunction

    function automatic logic signed [ERR_W-1:0] add_sat(input logic signed [ERR_W-1:0] a,
                                                        input logic signed [ERR_W-1:0] b);
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        return sat_err(s);
    endfunction

endpackage

>>> hdl/amd_if.sv
// Stream interfaces for the grey pixel input and the mono pixel output.
interface amd_in_if;
    logic                         valid;
    logic                         ready;
    logic [amd_pkg::PIXEL_W-1:0]  pixel_in;
    logic                         frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface amd_out_if;
    logic valid;
    logic ready;
    logic pixel_white;

    modport source (output valid, output pixel_white, input ready);
    modport sink (input valid, input pixel_white, output ready);
endinterface

>>> hdl/amd_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module amd_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/amd_issue.sv
// Issue stage: tracks the column, starts the line store reads and holds the pixel in flight.
module amd_issue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [amd_pkg::CNT_W-1:0]         width_eff,
    input  logic                              take,
    input  logic                              advance,
    input  logic [amd_pkg::PIXEL_W-1:0]       pixel_in,
    input  logic                              frame_start,
    output logic                              item_valid,
    output amd_pkg::amd_item_t                item,
    output logic [amd_pkg::ADDR_W-1:0]        rd_addr
);

    logic [amd_pkg::ADDR_W-1:0] pos_reg;
    logic [amd_pkg::ADDR_W-1:0] pos_next;
    logic [amd_pkg::ADDR_W-1:0] col;
    logic [amd_pkg::CNT_W-1:0]  col_inc;
    logic                       valid_reg;
    logic                       valid_next;
    amd_pkg::amd_item_t         item_reg;
    amd_pkg::amd_item_t         item_next;

    always_comb
    begin
        if (frame_start)
        begin
            col = '0;
        end
        else if (amd_pkg::CNT_W'(pos_reg) >= width_eff)
        begin
            col = '0;
        end
        else
        begin
            col = pos_reg;
        end

        col_inc = amd_pkg::CNT_W'(col) + amd_pkg::CNT_W'(1);

        pos_next = pos_reg;
        if (take)
        begin
            if (col_inc >= width_eff)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = col_inc[amd_pkg::ADDR_W-1:0];
            end
        end

        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end

        item_next.pixel       = pixel_in;
        item_next.frame_start = frame_start;
        item_next.col         = col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
    assign rd_addr    = col;

endmodule

>>> hdl/amd_diffuse.sv
// Diffusion stage: corrects the pixel, thresholds it and spreads the error into the stores.
`include "atkinson_mono_dither_assert.svh"

module amd_diffuse (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              commit,
    input  amd_pkg::amd_item_t                item,
    input  logic [amd_pkg::ERR_W-1:0]         next_rdata,
    input  logic [amd_pkg::ERR_W-1:0]         second_rdata,
    output amd_pkg::amd_wr_t                  next_wr,
    output amd_pkg::amd_wr_t                  second_wr,
    output logic                              white
);

    logic signed [amd_pkg::ERR_W-1:0] ahead1_reg;
    logic signed [amd_pkg::ERR_W-1:0] ahead1_next;
    logic signed [amd_pkg::ERR_W-1:0] ahead2_reg;
    logic signed [amd_pkg::ERR_W-1:0] ahead2_next;
    logic signed [amd_pkg::ERR_W-1:0] carry_reg;
    logic signed [amd_pkg::ERR_W-1:0] carry_next;
    logic signed [amd_pkg::ERR_W-1:0] pend_reg;
    logic signed [amd_pkg::ERR_W-1:0] pend_next;
    logic [amd_pkg::ADDR_W-1:0]       pend_addr_reg;
    logic                             pend_valid_reg;
    amd_pkg::amd_wr_t                 next_fwd_reg;
    amd_pkg::amd_wr_t                 second_fwd_reg;
    logic [amd_pkg::CNT_W-1:0]        fill_reg;
    logic [amd_pkg::CNT_W-1:0]        fill_next;
    logic [amd_pkg::CNT_W-1:0]        fill_base;
    logic [amd_pkg::CNT_W-1:0]        col_inc;

    logic                             row_start;
    logic                             unfilled;
    logic signed [amd_pkg::ERR_W-1:0] ahead1;
    logic signed [amd_pkg::ERR_W-1:0] ahead2;
    logic signed [amd_pkg::ERR_W-1:0] carry;
    logic signed [amd_pkg::ERR_W-1:0] above;
    logic signed [amd_pkg::ERR_W-1:0] second;
    logic signed [amd_pkg::VAL_W-1:0] value;
    logic signed [amd_pkg::VAL_W-1:0] diff;
    logic signed [amd_pkg::VAL_W-1:0] biased;
    logic signed [amd_pkg::ERR_W-1:0] err;

    always_comb
    begin
        row_start = (item.col == '0);
        col_inc   = amd_pkg::CNT_W'(item.col) + amd_pkg::CNT_W'(1);
        unfilled  = (amd_pkg::CNT_W'(item.col) >= fill_reg);

        ahead1 = row_start ? '0 : ahead1_reg;
        ahead2 = row_start ? '0 : ahead2_reg;
        carry  = row_start ? '0 : carry_reg;

        if (item.frame_start)
        begin
            above = '0;
        end
        else if (pend_valid_reg && (pend_addr_reg == item.col))
        begin
            above = pend_reg;
        end
        else if (next_fwd_reg.en && (next_fwd_reg.addr == item.col))
        begin
            above = $signed(next_fwd_reg.data);
        end
        else if (unfilled)
        begin
            above = '0;
        end
        else
        begin
            above = $signed(next_rdata);
        end

        if (item.frame_start)
        begin
            second = '0;
        end
        else if (second_fwd_reg.en && (second_fwd_reg.addr == item.col))
        begin
            second = $signed(second_fwd_reg.data);
        end
        else if (unfilled)
        begin
            second = '0;
        end
        else
        begin
            second = $signed(second_rdata);
        end

        value  = amd_pkg::VAL_W'(item.pixel) + amd_pkg::VAL_W'(above)
               + amd_pkg::VAL_W'(ahead1);
        white  = (value >= amd_pkg::QUANT_MID);
        diff   = value - (white ? amd_pkg::VAL_W'(amd_pkg::WHITE_LEVEL) : amd_pkg::VAL_W'(0));
        biased = diff + (diff[amd_pkg::VAL_W-1] ? amd_pkg::VAL_W'(amd_pkg::ERR_DIV - 1)
                                                 : amd_pkg::VAL_W'(0));
        err    = amd_pkg::ERR_W'(biased >>> amd_pkg::ERR_SHIFT);

        ahead1_next = amd_pkg::add_sat(ahead2, err);
        ahead2_next = err;
        carry_next  = err;
        pend_next   = amd_pkg::add_sat(amd_pkg::add_sat(second, carry), err);

        // The entry left of this column gets its last share now; at the start of a row that does
        // not start a frame, the finished entry of the previous row goes out unchanged.
        if (!row_start)
        begin
            next_wr.en   = 1'b1;
            next_wr.addr = item.col - amd_pkg::ADDR_W'(1);
            next_wr.data = amd_pkg::add_sat(pend_reg, err);
        end
        else if (pend_valid_reg && !item.frame_start)
        begin
            next_wr.en   = 1'b1;
            next_wr.addr = pend_addr_reg;
            next_wr.data = pend_reg;
        end
        else
        begin
            next_wr.en   = 1'b0;
            next_wr.addr = pend_addr_reg;
            next_wr.data = pend_reg;
        end

        second_wr.en   = 1'b1;
        second_wr.addr = item.col;
        second_wr.data = err;

        fill_base = item.frame_start ? '0 : fill_reg;
        fill_next = (col_inc > fill_base) ? col_inc : fill_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ahead1_reg     <= '0;
            ahead2_reg     <= '0;
            carry_reg      <= '0;
            pend_reg       <= '0;
            pend_addr_reg  <= '0;
            pend_valid_reg <= 1'b0;
            next_fwd_reg   <= '0;
            second_fwd_reg <= '0;
            fill_reg       <= '0;
        end
        else if (commit)
        begin
            ahead1_reg     <= ahead1_next;
            ahead2_reg     <= ahead2_next;
            carry_reg      <= carry_next;
            pend_reg       <= pend_next;
            pend_addr_reg  <= item.col;
            pend_valid_reg <= 1'b1;
            next_fwd_reg   <= next_wr;
            second_fwd_reg <= second_wr;
            fill_reg       <= fill_next;
        end
    end

    `AMD_ASSERT_NOW(a_fill_range, 1'b1, fill_reg <= amd_pkg::CNT_W'(amd_pkg::MAX_WIDTH), "fill count beyond the line store depth")
    `AMD_ASSERT_NOW(a_pend_filled, pend_valid_reg, amd_pkg::CNT_W'(pend_addr_reg) < fill_reg, "pending entry outside the filled range")
    `AMD_ASSERT_NOW(a_pend_left, commit && !row_start, pend_valid_reg && (pend_addr_reg == next_wr.addr), "no pending entry for the column to the left")

endmodule

>>> hdl/atkinson_mono_dither.sv
// Top level of the Atkinson error diffusion dither from 8-bit grey to one bit per pixel.
// Takes one grey pixel per clock in raster order, while video_out.ready does not hold back the
// output, and returns one black-or-white bit per pixel, registered in the issue stage and then in
// the output register; that rate is set by the two line stores, each of which can take one read
// and one write in the same cycle. Register line_width (byte address 0) gives the pixels per row,
// 1 to 1024; zero counts as one. A pixel with frame_start set clears all diffusion errors at once:
// the stores keep a fill count, so no clearing pass is needed after reset or at a frame start.
`include "atkinson_mono_dither_assert.svh"

module atkinson_mono_dither (
    input  logic                          clk,
    input  logic                          rst_n,
    amd_in_if.sink                        video_in,
    amd_out_if.source                     video_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [amd_pkg::PADDR_W-1:0]   paddr,
    input  logic [amd_pkg::PDATA_W-1:0]   pwdata,
    output logic [amd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [amd_pkg::LINE_WIDTH_W-1:0] line_width_reg;
    logic [amd_pkg::LINE_WIDTH_W-1:0] line_width_next;
    logic [amd_pkg::CNT_W-1:0]        width_eff;
    logic                             reg_sel;

    logic                             take;
    logic                             advance;
    logic                             s1_valid;
    amd_pkg::amd_item_t               s1_item;
    logic [amd_pkg::ADDR_W-1:0]       rd_addr;
    logic [amd_pkg::ERR_W-1:0]        next_rdata;
    logic [amd_pkg::ERR_W-1:0]        second_rdata;
    amd_pkg::amd_wr_t                 next_wr;
    amd_pkg::amd_wr_t                 second_wr;
    logic                             white;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             out_white_reg;

    always_comb
    begin
        reg_sel = ((paddr >> 2) == amd_pkg::PADDR_W'(amd_pkg::REG_LINE_WIDTH));

        line_width_next = line_width_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            line_width_next = pwdata[amd_pkg::LINE_WIDTH_W-1:0];
        end

        prdata = reg_sel ? amd_pkg::PDATA_W'(line_width_reg) : '0;

        if (line_width_reg == '0)
        begin
            width_eff = amd_pkg::CNT_W'(1);
        end
        else if (amd_pkg::WCMP_W'(line_width_reg) > amd_pkg::WCMP_W'(amd_pkg::MAX_WIDTH))
        begin
            width_eff = amd_pkg::CNT_W'(amd_pkg::MAX_WIDTH);
        end
        else
        begin
            width_eff = amd_pkg::CNT_W'(line_width_reg);
        end
    end

    assign pready = 1'b1;

    assign advance        = s1_valid && (!out_valid_reg || video_out.ready);
    assign video_in.ready = !s1_valid || advance;
    assign take           = video_in.valid && video_in.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (video_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= amd_pkg::LINE_WIDTH_W'(amd_pkg::LINE_WIDTH_RESET);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            line_width_reg <= line_width_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_white_reg <= white;
        end
    end

    assign video_out.valid       = out_valid_reg;
    assign video_out.pixel_white = out_white_reg;

    amd_issue u_issue (
        .clk         (clk),
        .rst_n       (rst_n),
        .width_eff   (width_eff),
        .take        (take),
        .advance     (advance),
        .pixel_in    (video_in.pixel_in),
        .frame_start (video_in.frame_start),
        .item_valid  (s1_valid),
        .item        (s1_item),
        .rd_addr     (rd_addr)
    );

    amd_ram #(
        .WIDTH (amd_pkg::ERR_W),
        .DEPTH (amd_pkg::MAX_WIDTH)
    ) u_next_ram (
        .clk   (clk),
        .we    (advance && next_wr.en),
        .waddr (next_wr.addr),
        .wdata (next_wr.data),
        .re    (take),
        .raddr (rd_addr),
        .rdata (next_rdata)
    );

    amd_ram #(
        .WIDTH (amd_pkg::ERR_W),
        .DEPTH (amd_pkg::MAX_WIDTH)
    ) u_second_ram (
        .clk   (clk),
        .we    (advance && second_wr.en),
        .waddr (second_wr.addr),
        .wdata (second_wr.data),
        .re    (take),
        .raddr (rd_addr),
        .rdata (second_rdata)
    );

    amd_diffuse u_diffuse (
        .clk          (clk),
        .rst_n        (rst_n),
        .commit       (advance),
        .item         (s1_item),
        .next_rdata   (next_rdata),
        .second_rdata (second_rdata),
        .next_wr      (next_wr),
        .second_wr    (second_wr),
        .white        (white)
    );

    `AMD_ASSERT_NEXT(a_take_loads, take, s1_valid, "transfer did not load the issue stage")
    `AMD_ASSERT_NEXT(a_advance_shows, advance, out_valid_reg, "finished pixel not presented")

endmodule

>>> tb/sv/amd_dither_checker.sv
// Checker for the Atkinson mono dither: predicts each mono pixel and compares it with the block's output.
module amd_dither_checker
    import amd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    amd_in_if                  vin,
    amd_out_if                 vout,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready,
    output int                 mismatch_count,
    output int                 pending_count,
    output int                 checked_count
);

    typedef logic signed [ERR_W-1:0] err_t;

    localparam logic [PADDR_W-1:0] LINE_WIDTH_ADDR = PADDR_W'(4 * REG_LINE_WIDTH);
    localparam int PRINT_CAP = 40;

    logic [LINE_WIDTH_W-1:0] width_reg;
    err_t                    below_row_err [MAX_WIDTH];
    err_t                    two_below_err [MAX_WIDTH];
    err_t                    ahead1_err;
    err_t                    ahead2_err;
    err_t                    carry_err;
    int                      column;
    bit                      expected_white [$];

    function automatic err_t clip_err(input int v);
        err_t r;
        if (v > ERR_MAX)
        begin
            r = err_t'(ERR_MAX);
        end
        else if (v < ERR_MIN)
        begin
            r = err_t'(ERR_MIN);
        end
        else
        begin
            r = err_t'(v);
        end
        return r;
    endfunction

    function automatic void clear_row_state();
        ahead1_err = '0;
        ahead2_err = '0;
        carry_err = '0;
    endfunction

    function automatic void clear_frame_state();
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            below_row_err[i] = '0;
            two_below_err[i] = '0;
        end
        clear_row_state();
        column = 0;
    endfunction

    function automatic bit dither_pixel(input logic [PIXEL_W-1:0] grey, input logic fs);
        int w;
        int x;
        int value;
        int err;
        bit white;
        w = int'(width_reg);
        if (w == 0)
        begin
            w = 1;
        end
        if (w > MAX_WIDTH)
        begin
            w = MAX_WIDTH;
        end
        if (fs)
        begin
            clear_frame_state();
        end
        if (column >= w)
        begin
            column = 0;
            clear_row_state();
        end
        x = column;
        value = int'(grey) + int'(below_row_err[x]) + int'(ahead1_err);
        white = (value >= QUANT_MID);
        err = (value - (white ? WHITE_LEVEL : 0)) / ERR_DIV;
        ahead1_err = clip_err(int'(ahead2_err) + err);
        ahead2_err = clip_err(err);
        below_row_err[x] = clip_err(int'(clip_err(int'(two_below_err[x]) + int'(carry_err))) + err);
        if (x > 0)
        begin
            below_row_err[x-1] = clip_err(int'(below_row_err[x-1]) + err);
        end
        two_below_err[x] = clip_err(err);
        carry_err = clip_err(err);
        column = x + 1;
        if (column >= w)
        begin
            column = 0;
            clear_row_state();
        end
        return white;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = LINE_WIDTH_W'(LINE_WIDTH_RESET);
            clear_frame_state();
            expected_white.delete();
            mismatch_count = 0;
            pending_count = 0;
            checked_count = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == LINE_WIDTH_ADDR)
            begin
                if (pwrite)
                begin
                    width_reg = pwdata[LINE_WIDTH_W-1:0];
                end
                else if (prdata !== PDATA_W'(width_reg))
                begin
                    report_mismatch($sformatf("line_width read 0x%0h, written 0x%0h",
                                              prdata, width_reg));
                end
            end
            if (vin.valid && vin.ready)
            begin
                expected_white.push_back(dither_pixel(vin.pixel_in, vin.frame_start));
            end
            if (vout.valid && vout.ready)
            begin
                if (expected_white.size() == 0)
                begin
                    report_mismatch($sformatf("mono pixel %0b transferred with none predicted",
                                              vout.pixel_white));
                end
                else
                begin
                    if (vout.pixel_white !== expected_white[0])
                    begin
                        report_mismatch($sformatf("result %0d pixel_white %0b, predicted %0b",
                                                  checked_count, vout.pixel_white,
                                                  expected_white[0]));
                    end
                    void'(expected_white.pop_front());
                    checked_count++;
                end
            end
            pending_count = expected_white.size();
        end
    end

endmodule

>>> tb/sv/tb_atkinson_mono_dither.sv
// Testbench top for the Atkinson mono dither: clock, reset, pixel and register stimulus, verdict.
module tb_atkinson_mono_dither;
    import amd_pkg::*;

    localparam int CYCLE_LIMIT = 150000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES = 12;
    localparam logic [PADDR_W-1:0] LINE_WIDTH_ADDR = PADDR_W'(4 * REG_LINE_WIDTH);

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int cycle_count;
    int pixels_sent;
    int widths_used;
    int send_idle;
    int recv_idle;
    bit hold_req;
    bit hold_active;

    int phase_width [PHASES] = '{1, 2, 3, 7, 16, 33, 5, 0, 12, 64, 1024, 2047};
    int phase_count [PHASES] = '{40, 61, 77, 90, 80, 140, 53, 20, 100, 130, 60, 90};

    amd_in_if  vin ();
    amd_out_if vout ();

    atkinson_mono_dither u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .video_in  (vin),
        .video_out (vout),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    amd_dither_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .vin            (vin),
        .vout           (vout),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_active)
        begin
            vout.ready <= 1'b0;
        end
        else
        begin
            vout.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        hold_active = 1'b0;
        forever
        begin
            wait (hold_req);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_active = 1'b0;
            hold_req = 1'b0;
        end
    end

    task automatic apb_access(input bit write, input logic [LINE_WIDTH_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= LINE_WIDTH_ADDR;
        pwdata <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_pixel(input logic [PIXEL_W-1:0] grey, input logic fs);
        while ($urandom_range(99) < send_idle)
        begin
            vin.valid <= 1'b0;
            @(negedge clk);
        end
        vin.valid <= 1'b1;
        vin.pixel_in <= grey;
        vin.frame_start <= fs;
        @(posedge clk);
        while (!vin.ready)
        begin
            @(posedge clk);
        end
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        vin.valid <= 1'b0;
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic set_width(input logic [LINE_WIDTH_W-1:0] width);
        settle();
        apb_access(1'b1, width);
        apb_access(1'b0, '0);
        widths_used++;
    endtask

    task automatic run_phase(input logic [LINE_WIDTH_W-1:0] width, input int count,
                             input bit with_hold);
        logic [PIXEL_W-1:0] grey;
        logic               fs;
        set_width(width);
        if (with_hold)
        begin
            hold_req = 1'b1;
        end
        grey = PIXEL_W'($urandom);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0: grey = '0;
                1: grey = '1;
                2: grey = PIXEL_W'($urandom_range(QUANT_MID, QUANT_MID - 1));
                3: grey = grey;
                default: grey = PIXEL_W'($urandom);
            endcase
            if (i == 0)
            begin
                fs = 1'($urandom_range(1));
            end
            else
            begin
                fs = ($urandom_range(49) == 0);
            end
            send_pixel(grey, fs);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        vin.valid = 1'b0;
        vin.pixel_in = '0;
        vin.frame_start = 1'b0;
        vout.ready = 1'b0;
        hold_req = 1'b0;
        pixels_sent = 0;
        widths_used = 1;
        send_idle = 8;
        recv_idle = 78;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // The reset width comes first, then a narrower width while the column is past it.
        apb_access(1'b0, '0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd127, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        set_width(LINE_WIDTH_W'(3));
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd127, 1'b0);
        send_pixel(8'd64, 1'b0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        set_width('0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd50, 1'b0);
        send_pixel(8'd255, 1'b0);
        set_width('1);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd128, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 5)
            begin
                send_idle = 78;
                recv_idle = 8;
            end
            else if (p == 9)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            run_phase(LINE_WIDTH_W'(phase_width[p]), phase_count[p], p == 9);
        end
        settle();

        $display("Sent %0d grey pixels over %0d line width settings, with frame starts.",
                 pixels_sent, widths_used);
        $display("Checked %0d mono pixels against the prediction, %0d mismatches.",
                 checked_count, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/amd_pkg.sv
hdl/amd_if.sv
hdl/amd_ram.sv
hdl/amd_issue.sv
hdl/amd_diffuse.sv
hdl/atkinson_mono_dither.sv
tb/sv/amd_dither_checker.sv
tb/sv/tb_atkinson_mono_dither.sv
